### sv/vlpi_pkg.sv
package vlpi_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int DATA_W  = 192;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [63:0] segment_in;
        logic [63:0] offset_in;
        logic [63:0] version_in;
    } in_word_t;

    typedef struct packed {
        status_t          status;
        logic [63:0]      found_segment;
        logic [63:0]      found_offset;
        logic [CNT_W-1:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic             mode;
        logic             invalid;
        logic [IDX_W-1:0] home;
        logic [63:0]      key;
        logic [63:0]      segment;
        logic [63:0]      offset;
        logic [63:0]      version;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } q_ctl_t;

endpackage

### sv/versioned_linear_probe_index.sv
// Hash index of 1024 slots with linear probing from the key's low 10 bits. Insert
// (mode 0) places a new key in the first empty slot or updates a present key when its
// version is not older; lookup (mode 1) returns segment and offset or not found. Key
// zero gives status invalid; an insert into a full table gives status table full. After
// reset a clearing pass empties the key memory, and full stays high meanwhile. Items
// are handled one at a time: each probed slot is read through the single read port of
// the slot memories, and a zero key is answered without a probe. A two-word input
// queue and a one-word result register let both sides stall on their own.
module versioned_linear_probe_index (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  vlpi_pkg::in_word_t  item,
    output logic                empty,
    input  logic                pop,
    output vlpi_pkg::out_word_t result
);

    logic             cmd_valid;
    vlpi_pkg::cmd_t   cmd;
    vlpi_pkg::q_ctl_t ctl;

    vlpi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ctl       (ctl)
    );

    vlpi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .ctl       (ctl),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### sv/vlpi_ram.sv
module vlpi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/vlpi_front.sv
module vlpi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  vlpi_pkg::in_word_t item,
    output logic              cmd_valid,
    output vlpi_pkg::cmd_t    cmd,
    input  vlpi_pkg::q_ctl_t  ctl
);

    vlpi_pkg::cmd_t                q_reg [vlpi_pkg::Q_DEPTH];
    vlpi_pkg::cmd_t                cmd_in;
    logic [vlpi_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [vlpi_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [vlpi_pkg::Q_CNT_W-1:0]  count_reg;
    logic [vlpi_pkg::Q_CNT_W-1:0]  count_next;
    logic                          push_ok;

    always_comb
    begin
        cmd_in.mode    = item.mode;
        cmd_in.invalid = (item.key == 64'd0);
        cmd_in.home    = item.key[vlpi_pkg::IDX_W-1:0];
        cmd_in.key     = item.key;
        cmd_in.segment = item.segment_in;
        cmd_in.offset  = item.offset_in;
        cmd_in.version = item.version_in;
    end

    assign full      = ctl.clearing
                       || (count_reg == vlpi_pkg::Q_CNT_W'(vlpi_pkg::Q_DEPTH));
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_ok && ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vlpi_pkg::Q_CNT_W'(vlpi_pkg::Q_DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !ctl.pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted word lost");

endmodule

### sv/vlpi_back.sv
module vlpi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  vlpi_pkg::cmd_t     cmd,
    output vlpi_pkg::q_ctl_t   ctl,
    output logic               empty,
    input  logic               pop,
    output vlpi_pkg::out_word_t result
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    state_t                      state_reg, state_next;
    logic [vlpi_pkg::IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [vlpi_pkg::IDX_W-1:0]  addr_reg, addr_next;
    logic [vlpi_pkg::IDX_W-1:0]  probe_reg, probe_next;
    logic [vlpi_pkg::IDX_W-1:0]  addr_inc;
    logic [vlpi_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    vlpi_pkg::cmd_t              cmd_reg, cmd_next;
    vlpi_pkg::out_word_t         res_reg, res_next;
    logic                        res_valid_reg, res_valid_next;

    logic                        key_we;
    logic [vlpi_pkg::IDX_W-1:0]  key_waddr;
    logic [63:0]                 key_wdata;
    logic                        data_we;
    logic                        rd_en;
    logic [vlpi_pkg::IDX_W-1:0]  rd_addr;
    logic [63:0]                 rd_key;
    logic [vlpi_pkg::DATA_W-1:0] rd_data;
    logic [63:0]                 rd_seg;
    logic [63:0]                 rd_off;
    logic [63:0]                 rd_ver;

    logic res_free;
    logic hit;
    logic slot_empty;
    logic last_probe;

    vlpi_ram #(.WIDTH(64), .DEPTH(vlpi_pkg::SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_key)
    );

    vlpi_ram #(.WIDTH(vlpi_pkg::DATA_W), .DEPTH(vlpi_pkg::SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (addr_reg),
        .wdata ({cmd_reg.version, cmd_reg.offset, cmd_reg.segment}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_seg     = rd_data[63:0];
    assign rd_off     = rd_data[127:64];
    assign rd_ver     = rd_data[191:128];
    assign res_free   = !res_valid_reg || pop;
    assign hit        = (rd_key == cmd_reg.key);
    assign slot_empty = (rd_key == 64'd0);
    assign last_probe = (probe_reg == vlpi_pkg::IDX_W'(vlpi_pkg::SLOTS - 1));
    assign addr_inc   = (addr_reg == vlpi_pkg::IDX_W'(vlpi_pkg::SLOTS - 1))
                        ? '0 : addr_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        key_we         = 1'b0;
        key_waddr      = addr_reg;
        key_wdata      = cmd_reg.key;
        data_we        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        ctl.pop        = 1'b0;
        ctl.clearing   = (state_reg == S_CLEAR);

        unique case (state_reg)
            S_CLEAR:
            begin
                key_we       = 1'b1;
                key_waddr    = clr_cnt_reg;
                key_wdata    = 64'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == vlpi_pkg::IDX_W'(vlpi_pkg::SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.invalid)
                    begin
                        if (res_free)
                        begin
                            ctl.pop                = 1'b1;
                            res_next.status        = vlpi_pkg::ST_INVALID;
                            res_next.found_segment = 64'd0;
                            res_next.found_offset  = 64'd0;
                            res_next.entry_count   = cnt_reg;
                            res_valid_next         = 1'b1;
                        end
                    end
                    else
                    begin
                        ctl.pop    = 1'b1;
                        cmd_next   = cmd;
                        rd_en      = 1'b1;
                        rd_addr    = cmd.home;
                        addr_next  = cmd.home;
                        probe_next = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (slot_empty || hit || last_probe)
                begin
                    if (res_free)
                    begin
                        res_next.found_segment = 64'd0;
                        res_next.found_offset  = 64'd0;
                        res_next.status        = vlpi_pkg::ST_OK;
                        if (cmd_reg.mode == vlpi_pkg::MODE_INSERT)
                        begin
                            if (slot_empty)
                            begin
                                key_we   = 1'b1;
                                data_we  = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else if (hit)
                            begin
                                data_we = (cmd_reg.version >= rd_ver);
                            end
                            else
                            begin
                                res_next.status = vlpi_pkg::ST_FULL;
                            end
                        end
                        else
                        begin
                            if (hit)
                            begin
                                res_next.found_segment = rd_seg;
                                res_next.found_offset  = rd_off;
                            end
                            else
                            begin
                                res_next.status = vlpi_pkg::ST_NOT_FOUND;
                            end
                        end
                        res_next.entry_count = cnt_next;
                        res_valid_next       = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else
                begin
                    addr_next  = addr_inc;
                    probe_next = probe_reg + 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = addr_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            addr_reg      <= '0;
            probe_reg     <= '0;
            cmd_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            cmd_reg       <= cmd_next;
            res_reg       <= res_next;
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= vlpi_pkg::CNT_W'(vlpi_pkg::SLOTS))
        else $error("entry count beyond table size");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !res_valid_reg && !ctl.pop)
        else $error("activity during clearing pass");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> cnt_reg >= $past(cnt_reg))
        else $error("entry count decreased");

    a_write_on_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        data_we |-> state_reg == S_CHECK && res_free && (hit || slot_empty))
        else $error("data written without resolved probe");

endmodule

### test/versioned_linear_probe_index_tb.sv
`timescale 1ns / 1ps

module versioned_linear_probe_index_tb;

    import vlpi_pkg::*;

    typedef enum {PROBE_HIT, PROBE_EMPTY, PROBE_WRAP} probe_end_t;

    localparam int RANDOM_ITEMS = 200;
    localparam int LOAD_CAP     = 450;
    localparam int BASE_CYCLES  = 20000;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    in_word_t  item    = '0;
    logic      full;
    logic      empty;
    out_word_t result;

    logic             no_idle      = 1'b0;
    int               error_count  = 0;
    longint           cycle_budget = 0;
    out_word_t        pending_results [$];
    logic [63:0]      stored_keys [$];

    logic [63:0]      idx_key [SLOTS] = '{default: '0};
    logic [63:0]      idx_segment [SLOTS];
    logic [63:0]      idx_offset [SLOTS];
    logic [63:0]      idx_version [SLOTS];
    logic [CNT_W-1:0] idx_count = '0;

    versioned_linear_probe_index dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_word_t make_word(logic mode, logic [63:0] key, logic [63:0] seg,
                                           logic [63:0] off, logic [63:0] ver);
        in_word_t w;
        w.mode       = mode;
        w.key        = key;
        w.segment_in = seg;
        w.offset_in  = off;
        w.version_in = ver;
        return w;
    endfunction

    function automatic probe_end_t probe_slots(input logic [63:0] key, output int slot,
                                               output int steps);
        int s;
        s = int'(key % SLOTS);
        for (steps = 1; steps <= SLOTS; steps++)
        begin
            if (idx_key[s] == '0)
            begin
                slot = s;
                return PROBE_EMPTY;
            end
            if (idx_key[s] == key)
            begin
                slot = s;
                return PROBE_HIT;
            end
            s = (s + 1) % SLOTS;
        end
        slot  = -1;
        steps = SLOTS;
        return PROBE_WRAP;
    endfunction

    function automatic out_word_t predict_index_result(input in_word_t w, output int steps);
        out_word_t  r;
        probe_end_t how;
        int         slot;
        r        = '0;
        r.status = ST_OK;
        steps    = 1;
        if (w.key == '0)
            r.status = ST_INVALID;
        else
        begin
            how = probe_slots(w.key, slot, steps);
            if (w.mode == MODE_INSERT)
            begin
                if (how == PROBE_WRAP)
                    r.status = ST_FULL;
                else if (how == PROBE_EMPTY || w.version_in >= idx_version[slot])
                begin
                    if (how == PROBE_EMPTY)
                    begin
                        idx_key[slot] = w.key;
                        idx_count++;
                        stored_keys.push_back(w.key);
                    end
                    idx_segment[slot] = w.segment_in;
                    idx_offset[slot]  = w.offset_in;
                    idx_version[slot] = w.version_in;
                end
            end
            else if (how == PROBE_HIT)
            begin
                r.found_segment = idx_segment[slot];
                r.found_offset  = idx_offset[slot];
            end
            else
                r.status = ST_NOT_FOUND;
        end
        r.entry_count = idx_count;
        return r;
    endfunction

    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        probe_end_t  how;
        int          slot;
        int          steps;
        do
        begin
            k = rand64();
            case ($urandom_range(0, 9))
                0, 1: k[IDX_W-1:0] = IDX_W'(SLOTS - 1 - $urandom_range(0, 7));
                2: k[IDX_W-1:0] =
                       stored_keys[$urandom_range(0, stored_keys.size() - 1)][IDX_W-1:0];
                default: ;
            endcase
            how = probe_slots(k, slot, steps);
        end
        while (k == '0 || how == PROBE_HIT);
        return k;
    endfunction

    function automatic logic [63:0] any_stored_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic send_word(input in_word_t w);
        int        gap;
        int        steps;
        out_word_t want;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        item = w;
        do @(posedge clk); while (full);
        want = predict_index_result(w, steps);
        pending_results.push_back(want);
        cycle_budget += steps + 16;
    endtask

    initial
    begin : result_checker
        out_word_t got;
        out_word_t want;
        int        stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            do @(posedge clk); while (empty);
            got = result;
            if (pending_results.size() == 0)
                log_error($sformatf("unexpected word: status %0d seg %h off %h count %0d",
                                    got.status, got.found_segment, got.found_offset,
                                    got.entry_count));
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found_segment !== want.found_segment
                    || got.found_offset !== want.found_offset
                    || got.entry_count !== want.entry_count)
                    log_error($sformatf({"expected status %0d seg %h off %h count %0d, ",
                                         "got status %0d seg %h off %h count %0d"},
                                        want.status, want.found_segment, want.found_offset,
                                        want.entry_count, got.status, got.found_segment,
                                        got.found_offset, got.entry_count));
            end
        end
    end

    initial
    begin : watchdog
        longint cycle_count;
        cycle_count = 0;
        while (cycle_count <= BASE_CYCLES + 4 * cycle_budget)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic test_invalid_key();
        send_word(make_word(MODE_INSERT, '0, '1, '1, '1));
        send_word(make_word(MODE_LOOKUP, '0, rand64(), rand64(), rand64()));
    endtask

    task automatic test_insert_lookup();
        send_word(make_word(MODE_INSERT, '1, '1, '1, '1));
        send_word(make_word(MODE_LOOKUP, '1, '0, '0, '0));
        send_word(make_word(MODE_INSERT, 64'h1, '0, '0, '0));
        send_word(make_word(MODE_LOOKUP, 64'h1, '1, '1, '1));
        send_word(make_word(MODE_LOOKUP, 64'h2, rand64(), rand64(), rand64()));
        send_word(make_word(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0, '0, '0));
    endtask

    task automatic test_probe_wrap();
        send_word(make_word(MODE_INSERT, 64'h8000_0000_0000_03FF, rand64(), rand64(), 64'h7));
        send_word(make_word(MODE_INSERT, 64'h0000_0000_0000_07FF, rand64(), rand64(), 64'h9));
        send_word(make_word(MODE_LOOKUP, 64'h0000_0000_0000_07FF, '0, '0, '0));
        send_word(make_word(MODE_LOOKUP, 64'h0000_0001_0000_03FF, '0, '0, '0));
        send_word(make_word(MODE_LOOKUP, 64'h8000_0000_0000_03FF, '0, '0, '0));
    endtask

    task automatic test_version_order();
        logic [63:0] key;
        key = 64'h5A5A_0000_0000_0100;
        send_word(make_word(MODE_INSERT, key, 64'hA1, 64'hB1, 64'd100));
        send_word(make_word(MODE_INSERT, key, 64'hA2, 64'hB2, 64'd99));
        send_word(make_word(MODE_LOOKUP, key, '0, '0, '0));
        send_word(make_word(MODE_INSERT, key, 64'hA3, 64'hB3, 64'd100));
        send_word(make_word(MODE_INSERT, key, 64'hA4, 64'hB4, '1));
        send_word(make_word(MODE_INSERT, key, 64'hA5, 64'hB5, '0));
        send_word(make_word(MODE_LOOKUP, key, '0, '0, '0));
    endtask

    task automatic test_random_traffic();
        in_word_t    w;
        int          pick;
        int          slot;
        int          steps;
        logic [63:0] ver;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n % 200) >= 170;
            pick    = $urandom_range(0, 99);
            w       = make_word(MODE_INSERT, '0, rand64(), rand64(), rand64());
            if (pick < 5)
                w.mode = 1'($urandom_range(0, 1));
            else if (pick < 40 && idx_count < LOAD_CAP)
                w.key = fresh_key();
            else if (pick < 60)
            begin
                w.key = any_stored_key();
                void'(probe_slots(w.key, slot, steps));
                ver = idx_version[slot];
                case ($urandom_range(0, 3))
                    0: w.version_in = ver;
                    1: w.version_in = ver - 1;
                    2: w.version_in = ver + 1;
                    default: ;
                endcase
            end
            else if (pick < 88)
            begin
                w.mode = MODE_LOOKUP;
                w.key  = any_stored_key();
            end
            else
            begin
                w.mode = MODE_LOOKUP;
                w.key  = fresh_key();
            end
            send_word(w);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_fill_table();
        logic [63:0] key;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (idx_key[s] == '0)
            begin
                key             = rand64();
                key[IDX_W-1:0]  = IDX_W'(s);
                key[63]         = 1'b1;
                send_word(make_word(MODE_INSERT, key, rand64(), rand64(), rand64()));
            end
        end
        send_word(make_word(MODE_INSERT, fresh_key(), rand64(), rand64(), rand64()));
        send_word(make_word(MODE_LOOKUP, fresh_key(), rand64(), rand64(), rand64()));
        key = any_stored_key();
        send_word(make_word(MODE_LOOKUP, key, '0, '0, '0));
        send_word(make_word(MODE_INSERT, key, rand64(), rand64(), '1));
        send_word(make_word(MODE_LOOKUP, key, '0, '0, '0));
        send_word(make_word(MODE_INSERT, '0, rand64(), rand64(), rand64()));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_invalid_key();
        test_insert_lookup();
        test_probe_wrap();
        test_version_order();
        test_random_traffic();
        test_fill_table();
        @(negedge clk);
        push = 1'b0;
        wait (pending_results.size() == 0);
        // hold for stray words
        repeat (1100) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
